// ===== design/abwp_pkg.sv =====
// ----------------------------------------------------------------------------
// abwp_pkg
// shared widths, register indexes and the item record that travels along
// the division cell chain
// ----------------------------------------------------------------------------
package abwp_pkg;

  localparam int CoordBits  = 16;
  localparam int TotalBits  = 24;
  localparam int LenBits    = 16;
  localparam int ProcBits   = 11;
  localparam int WeightBits = 11;
  localparam int ProdBits   = CoordBits + ProcBits;
  localparam int DivdBits   = ProdBits + 1;
  localparam int NumCells   = DivdBits;

  localparam logic [WeightBits-1:0] WeightMax = WeightBits'(1024);

  localparam int CfgAddrBits = 2;
  localparam int CfgDataBits = 16;

  localparam logic [CfgAddrBits-1:0] CfgRowLength = 2'd0;
  localparam logic [CfgAddrBits-1:0] CfgColLength = 2'd1;
  localparam logic [CfgAddrBits-1:0] CfgProcCount = 2'd2;

  typedef struct packed {
    logic                valid;
    logic                err;
    logic                last;
    logic                clr;
    logic [LenBits-1:0]  rem_row;
    logic [DivdBits-1:0] quo_row;
    logic [LenBits-1:0]  rem_col;
    logic [DivdBits-1:0] quo_col;
  } cell_t;

endpackage

// ===== design/alignment_block_weight_prefix.sv =====
// ----------------------------------------------------------------------------
// alignment_block_weight_prefix
// subproblem weight and saturating running total per alignment breakpoint
// ----------------------------------------------------------------------------
// pipeline: step stage, multiply stage, 28 division cells and output register
//   lie between an accepted breakpoint and its result item
// throughput: one item per cycle; the whole chain holds while the output
//   item waits, and a list-start point is taken in but gives no result
// reset: asynchronous, clears the chain and list state, lengths and
//   processor count return to 1
module alignment_block_weight_prefix (
  input  logic                             clk_i,
  input  logic                             rst_ni,

  input  logic                             cfg_we_i,
  input  logic [abwp_pkg::CfgAddrBits-1:0] cfg_addr_i,
  input  logic [abwp_pkg::CfgDataBits-1:0] cfg_wdata_i,

  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [31:0]                      s_axis_tdata,  // point_row, point_col
  input  logic                             s_axis_tuser,  // first_point
  input  logic                             s_axis_tlast,  // last_point

  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [39:0]                      m_axis_tdata,  // block_weight, running_total
  output logic                             m_axis_tuser,  // order_error
  output logic                             m_axis_tlast   // last_result
);

  localparam int NC = abwp_pkg::NumCells;
  localparam int WB = abwp_pkg::WeightBits;
  localparam int TB = abwp_pkg::TotalBits;

  logic [abwp_pkg::LenBits-1:0]  row_len_q, col_len_q;
  logic [abwp_pkg::ProcBits-1:0] proc_q;
  logic [abwp_pkg::LenBits-1:0]  div_row, div_col;

  logic en, accept;

  abwp_pkg::cell_t chain [NC+1];

  logic [abwp_pkg::DivdBits-1:0] wmax;
  logic [WB-1:0]                 weight;
  logic [TB-1:0]                 base;
  logic [TB:0]                   sum;
  logic [TB-1:0]                 new_total;

  logic          out_valid_q;
  logic [WB-1:0] out_weight_q;
  logic [TB-1:0] total_q;
  logic          out_err_q, out_last_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_len_q <= abwp_pkg::LenBits'(1);
      col_len_q <= abwp_pkg::LenBits'(1);
      proc_q    <= abwp_pkg::ProcBits'(1);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        abwp_pkg::CfgRowLength: row_len_q <= cfg_wdata_i[abwp_pkg::LenBits-1:0];
        abwp_pkg::CfgColLength: col_len_q <= cfg_wdata_i[abwp_pkg::LenBits-1:0];
        abwp_pkg::CfgProcCount: proc_q    <= cfg_wdata_i[abwp_pkg::ProcBits-1:0];
        default: ;
      endcase
    end
  end

  assign div_row = (row_len_q == '0) ? abwp_pkg::LenBits'(1) : row_len_q;
  assign div_col = (col_len_q == '0) ? abwp_pkg::LenBits'(1) : col_len_q;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;

  abwp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .accept_i      (accept),
    .point_row_i   (s_axis_tdata[15:0]),
    .point_col_i   (s_axis_tdata[31:16]),
    .first_point_i (s_axis_tuser),
    .last_point_i  (s_axis_tlast),
    .proc_count_i  (proc_q),
    .div_row_i     (div_row),
    .div_col_i     (div_col),
    .cell_o        (chain[0])
  );

  for (genvar g = 0; g < NC; g++) begin : g_cell
    abwp_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .div_row_i (div_row),
      .div_col_i (div_col),
      .cell_i    (chain[g]),
      .cell_o    (chain[g+1])
    );
  end

  // weight and running total
  always_comb begin
    wmax = (chain[NC].quo_row > chain[NC].quo_col) ? chain[NC].quo_row : chain[NC].quo_col;
    weight = (wmax > abwp_pkg::DivdBits'(abwp_pkg::WeightMax)) ? abwp_pkg::WeightMax
                                                                : wmax[WB-1:0];
    base      = chain[NC].clr ? '0 : total_q;
    sum       = {1'b0, base} + (TB+1)'(weight);
    new_total = sum[TB] ? '1 : sum[TB-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      total_q     <= '0;
    end else if (en) begin
      out_valid_q <= chain[NC].valid;
      if (chain[NC].valid) begin
        total_q <= new_total;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && chain[NC].valid) begin
      out_weight_q <= weight;
      out_err_q    <= chain[NC].err;
      out_last_q   <= chain[NC].last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, total_q, out_weight_q};
  assign m_axis_tuser  = out_err_q;
  assign m_axis_tlast  = out_last_q;

  // checks
  a_err_zero_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[WB-1:0] == '0)
    else $error("order error item carries a nonzero weight");

  a_weight_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[WB-1:0] <= abwp_pkg::WeightMax)
    else $error("weight above processor limit");

  a_chain_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(chain[NC].valid) && $stable(total_q))
    else $error("cell chain moved while output stalled");

endmodule

// ===== design/abwp_cell.sv =====
// ----------------------------------------------------------------------------
// abwp_cell
// one restoring division step for the row and the column share, registered
// ----------------------------------------------------------------------------
module abwp_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic [abwp_pkg::LenBits-1:0] div_row_i,
  input  logic [abwp_pkg::LenBits-1:0] div_col_i,
  input  abwp_pkg::cell_t              cell_i,
  output abwp_pkg::cell_t              cell_o
);

  logic [abwp_pkg::LenBits:0] sh_row, sh_col;
  logic [abwp_pkg::LenBits:0] sub_row, sub_col;
  logic                       ge_row, ge_col;
  abwp_pkg::cell_t            cell_d, cell_q;

  always_comb begin
    sh_row  = {cell_i.rem_row, cell_i.quo_row[abwp_pkg::DivdBits-1]};
    sh_col  = {cell_i.rem_col, cell_i.quo_col[abwp_pkg::DivdBits-1]};
    sub_row = sh_row - {1'b0, div_row_i};
    sub_col = sh_col - {1'b0, div_col_i};
    ge_row  = sh_row >= {1'b0, div_row_i};
    ge_col  = sh_col >= {1'b0, div_col_i};

    cell_d         = cell_i;
    cell_d.rem_row = ge_row ? sub_row[abwp_pkg::LenBits-1:0] : sh_row[abwp_pkg::LenBits-1:0];
    cell_d.rem_col = ge_col ? sub_col[abwp_pkg::LenBits-1:0] : sh_col[abwp_pkg::LenBits-1:0];
    cell_d.quo_row = {cell_i.quo_row[abwp_pkg::DivdBits-2:0], ge_row};
    cell_d.quo_col = {cell_i.quo_col[abwp_pkg::DivdBits-2:0], ge_col};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ===== design/abwp_front.sv =====
// ----------------------------------------------------------------------------
// abwp_front
// breakpoint tracking, step and order check, then step times processor
// count plus rounding term as the dividends for the cell chain
// ----------------------------------------------------------------------------
module abwp_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           accept_i,
  input  logic [abwp_pkg::CoordBits-1:0] point_row_i,
  input  logic [abwp_pkg::CoordBits-1:0] point_col_i,
  input  logic                           first_point_i,
  input  logic                           last_point_i,
  input  logic [abwp_pkg::ProcBits-1:0]  proc_count_i,
  input  logic [abwp_pkg::LenBits-1:0]   div_row_i,
  input  logic [abwp_pkg::LenBits-1:0]   div_col_i,
  output abwp_pkg::cell_t                cell_o
);

  logic [abwp_pkg::CoordBits-1:0] prev_row_q, prev_col_q;
  logic                           have_prev_q, new_list_q;
  logic                           start;
  logic                           err;

  logic                           a_valid_q, a_err_q, a_last_q, a_clr_q;
  logic [abwp_pkg::CoordBits-1:0] a_step_row_q, a_step_col_q;

  logic [abwp_pkg::ProdBits-1:0]  prod_row, prod_col;
  abwp_pkg::cell_t                b_d, b_q;

  assign start = first_point_i || !have_prev_q;
  assign err   = (point_row_i < prev_row_q) || (point_col_i < prev_col_q);

  // list tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_row_q  <= '0;
      prev_col_q  <= '0;
      have_prev_q <= 1'b0;
      new_list_q  <= 1'b0;
    end else if (accept_i) begin
      prev_row_q  <= point_row_i;
      prev_col_q  <= point_col_i;
      have_prev_q <= !last_point_i;
      new_list_q  <= start;
    end
  end

  // step stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= accept_i && !start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_err_q      <= err;
      a_last_q     <= last_point_i;
      a_clr_q      <= new_list_q;
      a_step_row_q <= err ? '0 : point_row_i - prev_row_q;
      a_step_col_q <= err ? '0 : point_col_i - prev_col_q;
    end
  end

  // dividend stage
  always_comb begin
    prod_row = abwp_pkg::ProdBits'(a_step_row_q) * abwp_pkg::ProdBits'(proc_count_i);
    prod_col = abwp_pkg::ProdBits'(a_step_col_q) * abwp_pkg::ProdBits'(proc_count_i);

    b_d         = '0;
    b_d.valid   = a_valid_q;
    b_d.err     = a_err_q;
    b_d.last    = a_last_q;
    b_d.clr     = a_clr_q;
    b_d.quo_row = {1'b0, prod_row} + abwp_pkg::DivdBits'(div_row_i - 1'b1);
    b_d.quo_col = {1'b0, prod_col} + abwp_pkg::DivdBits'(div_col_i - 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q <= '0;
    end else if (en_i) begin
      b_q <= b_d;
    end
  end

  assign cell_o = b_q;

endmodule

// ===== bench/block_weight_checker.sv =====
// ----------------------------------------------------------------------------
// block_weight_checker
// watches the register port and both streams of the block weight unit,
// predicts weight, running total and flags for every breakpoint item taken
// in that does not start a list, and compares each result item with the oldest prediction
// ----------------------------------------------------------------------------
module block_weight_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,

  input  logic                             cfg_we_i,
  input  logic [abwp_pkg::CfgAddrBits-1:0] cfg_addr_i,
  input  logic [abwp_pkg::CfgDataBits-1:0] cfg_wdata_i,

  input  logic                             pt_valid_i,
  input  logic                             pt_ready_i,
  input  logic [31:0]                      pt_data_i,   // point_row, point_col
  input  logic                             pt_first_i,  // first_point
  input  logic                             pt_last_i,   // last_point

  input  logic                             wt_valid_i,
  input  logic                             wt_ready_i,
  input  logic [39:0]                      wt_data_i,   // block_weight, running_total
  input  logic                             wt_err_i,    // order_error
  input  logic                             wt_last_i,   // last_result

  output int                               mismatches_o,
  output int                               pending_o
);

  localparam int CoordBits  = abwp_pkg::CoordBits;
  localparam int LenBits    = abwp_pkg::LenBits;
  localparam int ProcBits   = abwp_pkg::ProcBits;
  localparam int WeightBits = abwp_pkg::WeightBits;
  localparam int TotalBits  = abwp_pkg::TotalBits;

  localparam longint unsigned TotalMax = (64'd1 << TotalBits) - 64'd1;
  localparam int PadLsb = WeightBits + TotalBits;

  typedef struct packed {
    logic [WeightBits-1:0] weight;
    logic [TotalBits-1:0]  total;
    logic                  err;
    logic                  last;
  } weight_res_t;

  weight_res_t          weights_due[$];
  weight_res_t          oldest;

  logic [LenBits-1:0]   row_len;
  logic [LenBits-1:0]   col_len;
  logic [ProcBits-1:0]  procs;
  logic [CoordBits-1:0] prev_row;
  logic [CoordBits-1:0] prev_col;
  logic                 holding;
  logic [TotalBits-1:0] list_total;

  function automatic longint unsigned proc_share(input logic [CoordBits-1:0] step,
                                                 input logic [LenBits-1:0] len);
    longint unsigned divisor;
    longint unsigned prod;
    divisor = (len == '0) ? 64'd1 : 64'(len);
    prod = 64'(step) * 64'(procs);
    return (prod + divisor - 64'd1) / divisor;
  endfunction

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    mismatches_o++;
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  task automatic weigh_point(input logic [CoordBits-1:0] row,
                             input logic [CoordBits-1:0] col,
                             input logic first, input logic last);
    weight_res_t     res;
    longint unsigned row_share;
    longint unsigned col_share;
    longint unsigned weight;
    longint unsigned sum;
    if (first || !holding) begin
      list_total = '0;
    end else begin
      res.err = (row < prev_row) || (col < prev_col);
      weight = 64'd0;
      if (!res.err) begin
        row_share = proc_share(row - prev_row, row_len);
        col_share = proc_share(col - prev_col, col_len);
        weight = (row_share > col_share) ? row_share : col_share;
        if (weight > 64'(abwp_pkg::WeightMax)) weight = 64'(abwp_pkg::WeightMax);
      end
      sum = 64'(list_total) + weight;
      list_total = (sum > TotalMax) ? '1 : sum[TotalBits-1:0];
      res.weight = weight[WeightBits-1:0];
      res.total = list_total;
      res.last = last;
      weights_due.insert(weights_due.size(), res);
    end
    prev_row = row;
    prev_col = col;
    holding = !last;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_len = LenBits'(1);
      col_len = LenBits'(1);
      procs = ProcBits'(1);
      prev_row = '0;
      prev_col = '0;
      holding = 1'b0;
      list_total = '0;
      weights_due.delete();
      mismatches_o = 0;
      pending_o = 0;
    end else begin
      if (wt_valid_i && wt_ready_i) begin
        if (weights_due.size() == 0) begin
          flag_mismatch("unexpected result item, block_weight", wt_data_i[WeightBits-1:0], 0);
        end else begin
          oldest = weights_due[0];
          weights_due.delete(0);
          if (wt_data_i[WeightBits-1:0] !== oldest.weight)
            flag_mismatch("block_weight", wt_data_i[WeightBits-1:0], oldest.weight);
          if (wt_data_i[WeightBits +: TotalBits] !== oldest.total)
            flag_mismatch("running_total", wt_data_i[WeightBits +: TotalBits], oldest.total);
          if (wt_data_i[39:PadLsb] !== '0)
            flag_mismatch("tdata padding", wt_data_i[39:PadLsb], 0);
          if (wt_err_i !== oldest.err)
            flag_mismatch("order_error", wt_err_i, oldest.err);
          if (wt_last_i !== oldest.last)
            flag_mismatch("last_result", wt_last_i, oldest.last);
        end
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          abwp_pkg::CfgRowLength: row_len = cfg_wdata_i[LenBits-1:0];
          abwp_pkg::CfgColLength: col_len = cfg_wdata_i[LenBits-1:0];
          abwp_pkg::CfgProcCount: procs = cfg_wdata_i[ProcBits-1:0];
          default: ;
        endcase
      end
      if (pt_valid_i && pt_ready_i) begin
        weigh_point(pt_data_i[15:0], pt_data_i[31:16], pt_first_i, pt_last_i);
      end
      pending_o = weights_due.size();
    end
  end

endmodule

// ===== bench/alignment_block_weight_prefix_tb.sv =====
// ----------------------------------------------------------------------------
// alignment_block_weight_prefix_tb
// drives breakpoint lists into the block weight unit: a directed part for
// the list boundaries, order errors and extreme settings, then random lists
// over several register settings with bursty input and stalling output
// ----------------------------------------------------------------------------
module alignment_block_weight_prefix_tb;

  localparam int Latency = 31;
  localparam int Settle = Latency + 10;
  localparam int CycleLimit = 500000;
  localparam int RandomPhases = 8;
  localparam int PhaseItems = 175;
  localparam int HoldCycles = 400;

  typedef enum int {RxAlways, RxRandom, RxPattern, RxSparse} rx_mode_e;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;

  logic                             cfg_we = 1'b0;
  logic [abwp_pkg::CfgAddrBits-1:0] cfg_addr = '0;
  logic [abwp_pkg::CfgDataBits-1:0] cfg_wdata = '0;

  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [31:0]                      s_axis_tdata = '0;
  logic                             s_axis_tuser = 1'b0;
  logic                             s_axis_tlast = 1'b0;

  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [39:0]                      m_axis_tdata;
  logic                             m_axis_tuser;
  logic                             m_axis_tlast;

  int                               mismatches;
  int                               pending;
  int                               cycles = 0;

  bit                               gaps_on = 1'b0;
  int                               gap_max = 4;
  int                               burst_left = 0;
  rx_mode_e                         rx_mode = RxAlways;
  logic [15:0]                      rx_pattern = 16'hA5A5;
  bit                               hold_req = 1'b0;

  always #1 clk = ~clk;

  alignment_block_weight_prefix dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  block_weight_checker weight_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_wdata_i  (cfg_wdata),
    .pt_valid_i   (s_axis_tvalid),
    .pt_ready_i   (s_axis_tready),
    .pt_data_i    (s_axis_tdata),
    .pt_first_i   (s_axis_tuser),
    .pt_last_i    (s_axis_tlast),
    .wt_valid_i   (m_axis_tvalid),
    .wt_ready_i   (m_axis_tready),
    .wt_data_i    (m_axis_tdata),
    .wt_err_i     (m_axis_tuser),
    .wt_last_i    (m_axis_tlast),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: long hold-off on request, otherwise the phase's stall pattern
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        case (rx_mode)
          RxAlways: m_axis_tready <= 1'b1;
          RxRandom: m_axis_tready <= 1'($urandom_range(0, 1));
          RxPattern: begin
            m_axis_tready <= rx_pattern[0];
            rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
          end
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic write_reg(input logic [abwp_pkg::CfgAddrBits-1:0] idx,
                           input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [15:0] row_len, input logic [15:0] col_len,
                            input logic [15:0] procs);
    write_reg(abwp_pkg::CfgRowLength, row_len);
    write_reg(abwp_pkg::CfgColLength, col_len);
    write_reg(abwp_pkg::CfgProcCount, procs);
  endtask

  task automatic send_point(input logic [15:0] row, input logic [15:0] col,
                            input logic first, input logic last);
    if (gaps_on && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tdata <= {col, row};
    s_axis_tuser <= first;
    s_axis_tlast <= last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
  endtask

  // stop offering items until every result is out and the chain is empty
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (Settle) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_len();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      3: return 16'($urandom_range(1, 64));
      4: return 16'($urandom_range(1, 4096));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_start();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(0, 255));
      default: return 16'($urandom_range(0, 40000));
    endcase
  endfunction

  function automatic logic [15:0] next_coord(input logic [15:0] v);
    int room;
    int step;
    room = 65535 - int'(v);
    step = 0;
    case ($urandom_range(0, 19))
      0: begin
        if (v != 0) return v - 16'($urandom_range(1, int'(v)));
      end
      1, 2, 3: step = 0;
      4, 5, 6, 7, 8, 9, 10: step = $urandom_range(1, 64);
      11, 12, 13, 14, 15: step = $urandom_range(0, 4095);
      default: step = $urandom_range(0, room);
    endcase
    if (step > room) step = room;
    return v + 16'(step);
  endfunction

  task automatic random_lists(input int n);
    int          sent;
    int          len;
    int          k;
    logic [15:0] r;
    logic [15:0] c;
    logic        first_f;
    logic        last_f;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) == 0) begin
        send_point(16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
        sent++;
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        r = pick_start();
        c = pick_start();
        for (k = 0; k < len; k++) begin
          if (k > 0) begin
            r = next_coord(r);
            c = next_coord(c);
          end
          first_f = (k == 0) && ($urandom_range(0, 7) != 0);
          last_f = (k == len - 1) && ($urandom_range(0, 5) != 0);
          send_point(r, c, first_f, last_f);
          sent++;
        end
      end
    end
  endtask

  initial begin
    int          p;
    logic [15:0] procs;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    repeat (3) @(negedge clk);

    // reset settings, list boundaries and order errors
    send_point(16'd0, 16'd0, 1'b0, 1'b0);
    send_point(16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
    send_point(16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
    send_point(16'h0000, 16'hFFFF, 1'b0, 1'b0);
    send_point(16'h0000, 16'h0000, 1'b0, 1'b1);
    send_point(16'd5, 16'd5, 1'b1, 1'b1);
    send_point(16'd10, 16'd10, 1'b0, 1'b0);
    send_point(16'd12, 16'd11, 1'b1, 1'b0);
    send_point(16'd13, 16'd20, 1'b0, 1'b1);
    drain();

    // zero row length, zero processor count
    set_config(16'd0, 16'hFFFF, 16'd0);
    send_point(16'd0, 16'd0, 1'b1, 1'b0);
    send_point(16'd100, 16'd200, 1'b0, 1'b0);
    send_point(16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
    drain();

    // zero column length, processor count above the weight ceiling
    set_config(16'hFFFF, 16'd0, 16'd2047);
    send_point(16'd0, 16'd0, 1'b1, 1'b0);
    send_point(16'd1, 16'd0, 1'b0, 1'b0);
    send_point(16'd1, 16'd1, 1'b0, 1'b0);
    send_point(16'd40000, 16'd1, 1'b0, 1'b0);
    send_point(16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
    drain();

    for (p = 0; p < RandomPhases; p++) begin
      case ($urandom_range(0, 5))
        0: procs = 16'd0;
        1: procs = 16'd1;
        2: procs = 16'd1024;
        3: procs = 16'd2047;
        4: procs = 16'($urandom_range(1, 64));
        default: procs = 16'($urandom_range(0, 2047));
      endcase
      set_config(pick_len(), pick_len(), procs);
      gap_max = $urandom_range(1, 12);
      rx_pattern = 16'($urandom) | 16'h0001;
      if (p % 4 == 3) begin
        gaps_on = 1'b0;
        rx_mode = RxAlways;
      end else begin
        gaps_on = 1'b1;
        rx_mode = rx_mode_e'($urandom_range(0, 3));
      end
      if (p == 2 || p == 5) hold_req = 1'b1;
      random_lists(PhaseItems);
      drain();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
